// ===== design/hsm_transition_resolver_macros.svh =====
`ifndef HSM_TRANSITION_RESOLVER_MACROS_SVH
`define HSM_TRANSITION_RESOLVER_MACROS_SVH

// same-cycle implication
`define HTR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HTR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/htr_pkg.sv =====
package htr_pkg;

   typedef logic [7:0] sid_type;

   typedef enum logic [1:0] {
      MODE_EVENT    = 2'd0,
      MODE_WR_TRANS = 2'd1,
      MODE_WR_STATE = 2'd2,
      MODE_RESTART  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STS_DONE    = 2'd0,
      STS_NOMATCH = 2'd1,
      STS_ABOVE   = 2'd2,
      STS_SAME    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_INITIAL = 2'd0,
      REG_MAX     = 2'd1,
      REG_NTRANS  = 2'd2,
      REG_NSTATES = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_TSCAN,
      SEQ_SSCAN,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      sid_type    sid;
      logic [7:0] code;
      logic       any;
      sid_type    target;
   } trans_entry_type;

   typedef struct packed {
      sid_type sid;
      sid_type parent;
   } state_entry_type;

   typedef struct packed {
      logic       use_state;
      logic       level0;
      sid_type    level_id;
      sid_type    state_sid;
      sid_type    trans_sid;
      logic [7:0] trans_code;
      logic       trans_any;
      logic [7:0] ev_code;
      logic       ev_any;
   } match_req_type;

   typedef struct packed {
      logic sid_eq;
      logic trans_hit;
   } match_rsp_type;

   localparam int TRANS_W = $bits(trans_entry_type);
   localparam int STATE_W = $bits(state_entry_type);

endpackage

// ===== design/htr_req_if.sv =====
interface htr_req_if import htr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [5:0] index;
   logic [7:0] state_id;
   logic [7:0] event_code;
   logic       event_any;
   logic [7:0] next_state;
   logic [7:0] parent_state;

   modport source (output valid, mode, index, state_id, event_code, event_any,
                   next_state, parent_state, input ready);
   modport sink (input valid, mode, index, state_id, event_code, event_any,
                 next_state, parent_state, output ready);
endinterface

// ===== design/htr_rsp_if.sv =====
interface htr_rsp_if import htr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       exit_fired;
   logic       entry_fired;
   sid_type    left_state;
   sid_type    target_state;
   sid_type    current_state;

   modport source (output valid, status, exit_fired, entry_fired, left_state,
                   target_state, current_state, input ready);
   modport sink (input valid, status, exit_fired, entry_fired, left_state,
                 target_state, current_state, output ready);
endinterface

// ===== design/htr_ram.sv =====
module htr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/htr_match.sv =====
module htr_match import htr_pkg::*; (
   input  match_req_type mreq,
   output match_rsp_type mrsp
);

   sid_type cmp_sid;
   logic    ev_ok;

   // one id comparator shared by the transition and state scans
   always_comb begin
      cmp_sid = mreq.use_state ? mreq.state_sid : mreq.trans_sid;
      mrsp.sid_eq = (cmp_sid == mreq.level_id);
      ev_ok = (mreq.level0 && mreq.trans_any) ||
              ((mreq.trans_any == mreq.ev_any) &&
               (mreq.trans_any || (mreq.trans_code == mreq.ev_code)));
      mrsp.trans_hit = mrsp.sid_eq && ev_ok;
   end

endmodule

// ===== design/hsm_transition_resolver.sv =====
// Channel | Dir | Carries
// req_ch  | in  | event, table write or restart transaction
// rsp_ch  | out | one result per transaction
// csr_*   | in  | APB-style register port, pready tied high
//
// Write and restart transactions go from idle straight to the finish step, then wait for the output.
// An event runs per hierarchy level, for at most MAX_LEVELS levels, a transition
// scan and, if no transition matches, a state scan, one table entry a cycle through
// each RAM read port and the shared id comparator.
// Reset clears control and registers only; tables are undefined until written.
// A stalled result holds the block in its finish step; req_ch.ready is low meanwhile.
`include "hsm_transition_resolver_macros.svh"

module hsm_transition_resolver import htr_pkg::*; #(
   parameter int TRANS_DEPTH = 64,
   parameter int STATE_DEPTH = 32,
   parameter int MAX_LEVELS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   htr_req_if.sink     req_ch,
   htr_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int TAW = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;
   localparam int SAW = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
   localparam int CNTMAX = (TRANS_DEPTH > STATE_DEPTH) ? TRANS_DEPTH : STATE_DEPTH;
   localparam int CW = $clog2(CNTMAX + 1);
   localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   // configuration
   sid_type    init_ff, max_ff;
   logic [6:0] ntrans_ff;
   logic [5:0] nstates_ff;
   logic       cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= '0;
         max_ff     <= 8'hff;
         ntrans_ff  <= '0;
         nstates_ff <= '0;
      end else if (cfg_wr) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_INITIAL: init_ff    <= csr_pwdata[7:0];
            REG_MAX:     max_ff     <= csr_pwdata[7:0];
            REG_NTRANS:  ntrans_ff  <= csr_pwdata[6:0];
            REG_NSTATES: nstates_ff <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_INITIAL: csr_prdata = {24'd0, init_ff};
         REG_MAX:     csr_prdata = {24'd0, max_ff};
         REG_NTRANS:  csr_prdata = {25'd0, ntrans_ff};
         REG_NSTATES: csr_prdata = {26'd0, nstates_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // sequencer registers
   seq_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic [LW-1:0] level_ff, level_in;
   sid_type       lid_ff, lid_in;
   logic          hit_ff, hit_in;
   sid_type       tgt_ff, tgt_in;
   mode_type      mode_ff, mode_in;
   logic [7:0]    code_ff, code_in;
   logic          any_ff, any_in;
   sid_type       ps_ff, ps_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic          rsp_exit_ff, rsp_exit_in;
   logic          rsp_entry_ff, rsp_entry_in;
   sid_type       rsp_left_ff, rsp_left_in;
   sid_type       rsp_tgt_ff, rsp_tgt_in;
   sid_type       rsp_cur_ff, rsp_cur_in;

   logic [CW-1:0] nt, ns;
   logic          issue, accept, load;

   // tables
   logic            t_we, s_we;
   trans_entry_type t_wdata, t_rdata;
   state_entry_type s_wdata, s_rdata;

   htr_ram #(.WIDTH(TRANS_W), .DEPTH(TRANS_DEPTH)) u_trans_ram (
      .clock (clock),
      .we    (t_we),
      .waddr (TAW'(req_ch.index)),
      .wdata (t_wdata),
      .raddr (cnt_ff[TAW-1:0]),
      .rdata (t_rdata)
   );

   htr_ram #(.WIDTH(STATE_W), .DEPTH(STATE_DEPTH)) u_state_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (SAW'(req_ch.index)),
      .wdata (s_wdata),
      .raddr (cnt_ff[SAW-1:0]),
      .rdata (s_rdata)
   );

   match_req_type mreq;
   match_rsp_type mrsp;

   htr_match u_match (
      .mreq (mreq),
      .mrsp (mrsp)
   );

   always_comb begin
      mreq.use_state  = (state_ff == SEQ_SSCAN);
      mreq.level0     = (level_ff == '0);
      mreq.level_id   = lid_ff;
      mreq.state_sid  = s_rdata.sid;
      mreq.trans_sid  = t_rdata.sid;
      mreq.trans_code = t_rdata.code;
      mreq.trans_any  = t_rdata.any;
      mreq.ev_code    = code_ff;
      mreq.ev_any     = any_ff;
   end

   always_comb begin
      if (int'(ntrans_ff) > TRANS_DEPTH) begin
         nt = CW'(TRANS_DEPTH);
      end else begin
         nt = CW'(ntrans_ff);
      end
      if (int'(nstates_ff) > STATE_DEPTH) begin
         ns = CW'(STATE_DEPTH);
      end else begin
         ns = CW'(nstates_ff);
      end
   end

   assign req_ch.ready = (state_ff == SEQ_IDLE);
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      t_wdata.sid    = req_ch.state_id;
      t_wdata.code   = req_ch.event_code;
      t_wdata.any    = req_ch.event_any;
      t_wdata.target = req_ch.next_state;
      s_wdata.sid    = req_ch.state_id;
      s_wdata.parent = req_ch.parent_state;
      t_we = accept && (mode_type'(req_ch.mode) == MODE_WR_TRANS) &&
             (int'(req_ch.index) < TRANS_DEPTH);
      s_we = accept && (mode_type'(req_ch.mode) == MODE_WR_STATE) &&
             (int'(req_ch.index) < STATE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         level_ff     <= '0;
         hit_ff       <= 1'b0;
         ps_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         level_ff     <= level_in;
         hit_ff       <= hit_in;
         ps_ff        <= ps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lid_ff        <= lid_in;
      tgt_ff        <= tgt_in;
      mode_ff       <= mode_in;
      code_ff       <= code_in;
      any_ff        <= any_in;
      rsp_status_ff <= rsp_status_in;
      rsp_exit_ff   <= rsp_exit_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_tgt_ff    <= rsp_tgt_in;
      rsp_cur_ff    <= rsp_cur_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      level_in      = level_ff;
      lid_in        = lid_ff;
      hit_in        = hit_ff;
      tgt_in        = tgt_ff;
      mode_in       = mode_ff;
      code_in       = code_ff;
      any_in        = any_ff;
      ps_in         = ps_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_exit_in   = rsp_exit_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_tgt_in    = rsp_tgt_ff;
      rsp_cur_in    = rsp_cur_ff;
      issue         = 1'b0;
      load          = 1'b0;

      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               mode_in  = mode_type'(req_ch.mode);
               code_in  = req_ch.event_code;
               any_in   = req_ch.event_any;
               cnt_in   = '0;
               pend_in  = 1'b0;
               level_in = '0;
               lid_in   = ps_ff;
               hit_in   = 1'b0;
               tgt_in   = '0;
               if (mode_type'(req_ch.mode) == MODE_EVENT) begin
                  state_in = SEQ_TSCAN;
               end else begin
                  state_in = SEQ_FINISH;
               end
            end
         end
         SEQ_TSCAN: begin
            issue   = (cnt_ff < nt);
            pend_in = issue;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (pend_ff && mrsp.trans_hit) begin
               hit_in   = 1'b1;
               tgt_in   = t_rdata.target;
               state_in = SEQ_FINISH;
            end else if (!issue && !pend_ff) begin
               cnt_in   = '0;
               pend_in  = 1'b0;
               state_in = SEQ_SSCAN;
            end
         end
         SEQ_SSCAN: begin
            issue   = (cnt_ff < ns);
            pend_in = issue;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (pend_ff && mrsp.sid_eq) begin
               if (level_ff == LW'(MAX_LEVELS - 1)) begin
                  state_in = SEQ_FINISH;
               end else begin
                  lid_in   = s_rdata.parent;
                  level_in = level_ff + 1'b1;
                  cnt_in   = '0;
                  pend_in  = 1'b0;
                  state_in = SEQ_TSCAN;
               end
            end else if (!issue && !pend_ff) begin
               state_in = SEQ_FINISH;
            end
         end
         SEQ_FINISH: begin
            load = !rsp_valid_ff || rsp_ch.ready;
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_DONE;
               rsp_exit_in   = 1'b0;
               rsp_entry_in  = 1'b0;
               rsp_left_in   = ps_ff;
               rsp_tgt_in    = '0;
               case (mode_ff)
                  MODE_RESTART: begin
                     rsp_entry_in = 1'b1;
                     rsp_tgt_in   = init_ff;
                     ps_in        = init_ff;
                  end
                  MODE_EVENT: begin
                     if (!hit_ff) begin
                        rsp_status_in = STS_NOMATCH;
                     end else if (tgt_ff == ps_ff) begin
                        rsp_status_in = STS_SAME;
                        rsp_tgt_in    = tgt_ff;
                     end else begin
                        rsp_tgt_in  = tgt_ff;
                        rsp_exit_in = 1'b1;
                        if (tgt_ff <= max_ff) begin
                           rsp_entry_in = 1'b1;
                           ps_in        = tgt_ff;
                        end else begin
                           rsp_status_in = STS_ABOVE;
                        end
                     end
                  end
                  default: ;
               endcase
               rsp_cur_in = ps_in;
               state_in   = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.exit_fired    = rsp_exit_ff;
   assign rsp_ch.entry_fired   = rsp_entry_ff;
   assign rsp_ch.left_state    = rsp_left_ff;
   assign rsp_ch.target_state  = rsp_tgt_ff;
   assign rsp_ch.current_state = rsp_cur_ff;

   `HTR_ASSERT_NEXT(a_rsp_from_finish, clock, reset, (state_ff != SEQ_FINISH) && !rsp_valid_ff, !rsp_valid_ff, "result appeared outside finish step")
   `HTR_ASSERT_NEXT(a_ps_stable, clock, reset, state_ff != SEQ_FINISH, $stable(ps_ff), "present state changed outside finish step")
   `HTR_ASSERT_IMPLY(a_level_bound, clock, reset, 1'b1, level_ff <= LW'(MAX_LEVELS - 1), "hierarchy level beyond limit")
   `HTR_ASSERT_IMPLY(a_entry_cur, clock, reset, rsp_valid_ff && rsp_entry_ff, rsp_cur_ff == rsp_tgt_ff, "entry reported but current state is not the target")

endmodule
